@@ sv/sti_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sti_pkg;

  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  // one input transfer
  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  // one result transfer
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] smallest;
    logic signed [DATA_W-1:0] largest;
  } out_item_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic do_ins;
    logic do_del;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/sorted_table_insert_delete_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A result is strobed in the cycle after its transfer is accepted.
// Throughput: one operation per cycle; every cell compares and shifts in the same edge,
// and busy is only high during reset and in the cycle that follows it.
// The result strobe cannot be stalled by the receiver.
// Reset (synchronous, active low) empties the table; stored values are not cleared.
module sorted_table_insert_delete_unit #(
  parameter int CAPACITY = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire sti_pkg::in_item_t in_data,
  output logic                out_strobe,
  output sti_pkg::out_item_t  out_data
);

  localparam int UW = $clog2(CAPACITY + 1);

  typedef logic signed [sti_pkg::DATA_W-1:0] word_t;

  logic [UW-1:0]                used_r;
  logic [UW-1:0]                used_nxt;
  logic [sti_pkg::STATUS_W-1:0] status_r;
  logic [sti_pkg::STATUS_W-1:0] status_nxt;
  logic                         strobe_r;
  logic                         busy_r;

  logic                         accept;
  logic                         full;
  logic                         found;
  sti_pkg::cell_ctl_t           ctl;

  word_t                        cell_val [CAPACITY];
  logic  [CAPACITY-1:0]         cell_lt;
  logic  [CAPACITY-1:0]         cell_eq;
  logic  [CAPACITY-1:0]         cell_valid;
  logic  [CAPACITY-1:0]         cell_last;
  logic  [CAPACITY-1:0]         cell_left_lt;
  word_t                        cell_left [CAPACITY];
  word_t                        cell_right [CAPACITY];

  logic  [UW+sti_pkg::COUNT_W-1:0] used_ext;
  word_t                        largest_sel;

  assign accept = start && !busy_r;
  assign busy   = busy_r;
  assign full   = (used_r == UW'(CAPACITY));
  assign found  = |cell_eq;

  // neighbor wiring of the cell row
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign cell_valid[gi] = (UW'(gi) < used_r);
      assign cell_last[gi]  = (UW'(gi + 1) == used_r);
      if (gi == 0) begin : g_first
        assign cell_left_lt[gi] = 1'b1;
        assign cell_left[gi]    = in_data.value;
      end else begin : g_mid
        assign cell_left_lt[gi] = cell_lt[gi-1];
        assign cell_left[gi]    = cell_val[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_end
        assign cell_right[gi] = '0;
      end else begin : g_inner
        assign cell_right[gi] = cell_val[gi+1];
      end

      sti_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .key       (in_data.value),
        .valid     (cell_valid[gi]),
        .left_lt   (cell_left_lt[gi]),
        .left_val  (cell_left[gi]),
        .right_val (cell_right[gi]),
        .val       (cell_val[gi]),
        .lt        (cell_lt[gi]),
        .eq        (cell_eq[gi])
      );
    end
  endgenerate

  // operation decode, status and count update
  always_comb begin
    ctl.do_ins = 1'b0;
    ctl.do_del = 1'b0;
    used_nxt   = used_r;
    status_nxt = status_r;
    if (accept) begin
      if (in_data.op == sti_pkg::OP_INSERT) begin
        if (full) begin
          status_nxt = sti_pkg::ST_FULL;
        end else begin
          ctl.do_ins = 1'b1;
          used_nxt   = used_r + UW'(1);
          status_nxt = sti_pkg::ST_DONE;
        end
      end else begin
        if (found) begin
          ctl.do_del = 1'b1;
          used_nxt   = used_r - UW'(1);
          status_nxt = sti_pkg::ST_DONE;
        end else begin
          status_nxt = sti_pkg::ST_NOTFOUND;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      strobe_r <= 1'b0;
      busy_r   <= 1'b1;
      status_r <= sti_pkg::ST_DONE;
    end else begin
      used_r   <= used_nxt;
      strobe_r <= accept;
      busy_r   <= 1'b0;
      status_r <= status_nxt;
    end
  end

  // pick the last occupied cell
  always_comb begin
    largest_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      largest_sel = largest_sel | (cell_last[i] ? cell_val[i] : word_t'(0));
    end
  end

  // result fields come from the updated table
  assign used_ext            = {{sti_pkg::COUNT_W{1'b0}}, used_r};
  assign out_strobe          = strobe_r;
  assign out_data.status     = status_r;
  assign out_data.count      = used_ext[sti_pkg::COUNT_W-1:0];
  assign out_data.smallest   = (used_r != '0) ? cell_val[0] : word_t'(0);
  assign out_data.largest    = largest_sel;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(CAPACITY))
    else $error("entry count above capacity");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted transfer without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_strobe)
    else $error("result without accepted transfer");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == sti_pkg::ST_FULL) |-> full)
    else $error("full status with room left");

  generate
    for (gi = 1; gi < CAPACITY; gi++) begin : g_order_chk
      a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[gi] |-> (cell_val[gi-1] <= cell_val[gi]))
        else $error("table out of order");
    end
  endgenerate
`endif

endmodule

`default_nettype wire

@@ sv/sti_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sti_cell (
  input  wire                              clk,
  input  wire sti_pkg::cell_ctl_t          ctl,
  input  wire logic signed [sti_pkg::DATA_W-1:0] key,
  input  wire logic                        valid,
  input  wire logic                        left_lt,
  input  wire logic signed [sti_pkg::DATA_W-1:0] left_val,
  input  wire logic signed [sti_pkg::DATA_W-1:0] right_val,
  output logic signed [sti_pkg::DATA_W-1:0] val,
  output logic                             lt,
  output logic                             eq
);

  logic signed [sti_pkg::DATA_W-1:0] val_r;
  logic signed [sti_pkg::DATA_W-1:0] val_nxt;

  // local compare against the broadcast key
  assign lt  = valid && (val_r < key);
  assign eq  = valid && (val_r == key);
  assign val = val_r;

  // insert: entries below the slot stay, the slot takes the key, the rest shift up
  // delete: entries at or above the removed one shift down
  always_comb begin
    val_nxt = val_r;
    if (ctl.do_ins) begin
      if (!lt) begin
        if (left_lt) begin
          val_nxt = key;
        end else begin
          val_nxt = left_val;
        end
      end
    end else if (ctl.do_del) begin
      if (valid && !lt) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire
